FILE: src/assert_macros.svh
// Assertion macros used by the top-level RTL file of the array search tree block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: src/abst_pkg.sv
// Shared constants, codes and control types of the array search tree block
package abst_pkg;

    localparam int TREE_LEVELS_DEF = 10;
    localparam int KEY_W           = 32;
    localparam int MODE_W          = 2;
    localparam int STATUS_W        = 2;
    localparam int FIELD_W         = 10;
    localparam int RD_SEL_W        = 2;

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COUNT  = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DEPTH = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_MISS  = 2'd3;

    localparam logic [RD_SEL_W-1:0] RD_ROOT = 2'd0;
    localparam logic [RD_SEL_W-1:0] RD_WALK = 2'd1;
    localparam logic [RD_SEL_W-1:0] RD_SCAN = 2'd2;

    typedef struct packed {
        logic                clear;
        logic [RD_SEL_W-1:0] rd_sel;
        logic                p_root;
        logic                p_advance;
        logic                wr_insert;
        logic                cnt_inc;
        logic                scan_start;
        logic                scan_run;
        logic                scan_flush;
        logic                res_load;
        logic [STATUS_W-1:0] res_status;
        logic                res_slot;
        logic                res_leaf;
        logic                out_load;
    } abst_cmd_t;

    typedef struct packed {
        logic node_valid;
        logic key_eq;
        logic next_over;
        logic full;
        logic scan_end;
        logic clr_last;
        logic out_busy;
    } abst_sts_t;

endpackage

FILE: src/abst_ram.sv
// Generic single-write, single-read RAM with registered read data
module abst_ram
#(
    parameter int WIDTH = 33,
    parameter int DEPTH = 1024
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: src/abst_datapath.sv
// Datapath of the array search tree: node store, walk pointer, leaf scan and result registers
module abst_datapath
    import abst_pkg::*;
#(
    parameter int TREE_LEVELS = TREE_LEVELS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  abst_cmd_t                  cmd,
    output abst_sts_t                  sts,
    input  logic signed [KEY_W-1:0]    key,
    input  logic                       out_stall,
    output logic                       out_valid,
    output logic [STATUS_W-1:0]        status,
    output logic [FIELD_W-1:0]         slot,
    output logic [FIELD_W-1:0]         leaf_count,
    output logic [FIELD_W-1:0]         stored_count
);

    localparam int SLOT_W = TREE_LEVELS;
    localparam int DEPTH  = 1 << TREE_LEVELS;
    localparam logic [SLOT_W-1:0] SLOT_MAX = {SLOT_W{1'b1}};

    logic signed [KEY_W-1:0] key_reg;
    logic [SLOT_W-1:0]       p_reg;
    logic [SLOT_W-1:0]       count_reg;
    logic [SLOT_W-1:0]       count_next;
    logic [SLOT_W-1:0]       clr_reg;
    logic [SLOT_W-1:0]       scan_reg;
    logic                    live_reg;
    logic                    par_reg;
    logic                    even_reg;
    logic                    even_next;
    logic [SLOT_W-1:0]       internal_reg;
    logic [SLOT_W-1:0]       internal_next;
    logic                    out_valid_reg;

    logic [STATUS_W-1:0]     res_status_reg;
    logic [SLOT_W-1:0]       res_slot_reg;
    logic [FIELD_W-1:0]      res_leaf_reg;
    logic [STATUS_W-1:0]     out_status_reg;
    logic [FIELD_W-1:0]      out_slot_reg;
    logic [FIELD_W-1:0]      out_leaf_reg;
    logic [FIELD_W-1:0]      out_stored_reg;

    logic [KEY_W:0]          rd_data;
    logic [KEY_W:0]          wr_data;
    logic [SLOT_W-1:0]       rd_addr;
    logic [SLOT_W-1:0]       wr_addr;
    logic                    wr_en;
    logic                    node_valid;
    logic signed [KEY_W-1:0] node_key;
    logic                    go_right;
    logic [SLOT_W:0]         next_p;
    logic                    scan_proc;
    logic [FIELD_W-1:0]      leaf_value;

    assign node_valid = rd_data[KEY_W];
    assign node_key   = rd_data[KEY_W-1:0];
    assign go_right   = !(key_reg < node_key);
    assign next_p     = {p_reg, go_right};

    always_comb
    begin
        case (cmd.rd_sel)
            RD_WALK: rd_addr = next_p[SLOT_W-1:0];
            RD_SCAN: rd_addr = scan_reg;
            default: rd_addr = SLOT_W'(1);
        endcase
    end

    assign wr_en   = cmd.clear | cmd.wr_insert;
    assign wr_addr = cmd.clear ? clr_reg : p_reg;
    assign wr_data = cmd.clear ? '0 : {1'b1, key_reg};

    abst_ram
    #(
        .WIDTH (KEY_W + 1),
        .DEPTH (DEPTH)
    )
    u_node_ram
    (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // Internal nodes are counted per sibling pair; every stored child has a stored parent
    assign scan_proc = (cmd.scan_run | cmd.scan_flush) & live_reg;

    always_comb
    begin
        internal_next = internal_reg;
        even_next     = even_reg;
        if (scan_proc)
        begin
            if (par_reg)
            begin
                if (even_reg | node_valid)
                begin
                    internal_next = internal_reg + SLOT_W'(1);
                end
            end
            else
            begin
                even_next = node_valid;
            end
        end
    end

    assign leaf_value = FIELD_W'(count_reg - internal_next);
    assign count_next = cmd.cnt_inc ? count_reg + SLOT_W'(1) : count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_reg         <= '0;
            count_reg     <= '0;
            clr_reg       <= '0;
            scan_reg      <= '0;
            live_reg      <= 1'b0;
            par_reg       <= 1'b0;
            even_reg      <= 1'b0;
            internal_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.clear)
            begin
                clr_reg <= clr_reg + SLOT_W'(1);
            end
            if (cmd.p_root)
            begin
                p_reg <= SLOT_W'(1);
            end
            else if (cmd.p_advance)
            begin
                p_reg <= next_p[SLOT_W-1:0];
            end
            if (cmd.scan_start)
            begin
                scan_reg     <= SLOT_W'(2);
                live_reg     <= 1'b0;
                internal_reg <= '0;
                even_reg     <= 1'b0;
            end
            else
            begin
                internal_reg <= internal_next;
                even_reg     <= even_next;
                if (cmd.scan_run)
                begin
                    scan_reg <= scan_reg + SLOT_W'(1);
                    live_reg <= 1'b1;
                    par_reg  <= scan_reg[0];
                end
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.p_root)
        begin
            key_reg <= key;
        end
        if (cmd.res_load)
        begin
            res_status_reg <= cmd.res_status;
            res_slot_reg   <= cmd.res_slot ? p_reg : '0;
            res_leaf_reg   <= cmd.res_leaf ? leaf_value : '0;
        end
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_slot_reg   <= FIELD_W'(res_slot_reg);
            out_leaf_reg   <= res_leaf_reg;
            out_stored_reg <= FIELD_W'(count_reg);
        end
    end

    assign sts.node_valid = node_valid;
    assign sts.key_eq     = (node_key == key_reg);
    assign sts.next_over  = next_p[SLOT_W];
    assign sts.full       = (count_reg == SLOT_MAX);
    assign sts.scan_end   = (scan_reg == SLOT_MAX);
    assign sts.clr_last   = (clr_reg == SLOT_MAX);
    assign sts.out_busy   = out_valid_reg & out_stall;

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign slot         = out_slot_reg;
    assign leaf_count   = out_leaf_reg;
    assign stored_count = out_stored_reg;

endmodule

FILE: src/abst_ctrl.sv
// Controller state machine of the array search tree: clearing pass, walk, scan and hand-off
module abst_ctrl
    import abst_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [MODE_W-1:0] mode,
    input  abst_sts_t         sts,
    output abst_cmd_t         cmd
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_WALK  = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_FLUSH = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    logic [MODE_W-1:0] mode_reg;
    logic [MODE_W-1:0] mode_next;
    logic              accept;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid & ~in_stall;

    always_comb
    begin
        cmd        = '0;
        cmd.rd_sel = RD_ROOT;
        state_next = state_reg;
        mode_next  = accept ? mode : mode_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (mode)
                        MODE_INSERT:
                        begin
                            if (sts.full)
                            begin
                                cmd.res_load   = 1'b1;
                                cmd.res_status = STATUS_FULL;
                                state_next     = ST_DONE;
                            end
                            else
                            begin
                                cmd.p_root = 1'b1;
                                state_next = ST_WALK;
                            end
                        end
                        MODE_SEARCH:
                        begin
                            cmd.p_root = 1'b1;
                            state_next = ST_WALK;
                        end
                        MODE_COUNT:
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = ST_SCAN;
                        end
                        default:
                        begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = STATUS_OK;
                            state_next     = ST_DONE;
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                cmd.rd_sel = RD_WALK;
                if (mode_reg == MODE_INSERT)
                begin
                    if (!sts.node_valid)
                    begin
                        cmd.wr_insert  = 1'b1;
                        cmd.cnt_inc    = 1'b1;
                        cmd.res_load   = 1'b1;
                        cmd.res_status = STATUS_OK;
                        cmd.res_slot   = 1'b1;
                        state_next     = ST_DONE;
                    end
                    else if (sts.next_over)
                    begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = STATUS_DEPTH;
                        state_next     = ST_DONE;
                    end
                    else
                    begin
                        cmd.p_advance = 1'b1;
                    end
                end
                else
                begin
                    if (sts.node_valid && sts.key_eq)
                    begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = STATUS_OK;
                        cmd.res_slot   = 1'b1;
                        state_next     = ST_DONE;
                    end
                    else if (!sts.node_valid || sts.next_over)
                    begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = STATUS_MISS;
                        state_next     = ST_DONE;
                    end
                    else
                    begin
                        cmd.p_advance = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.rd_sel   = RD_SCAN;
                cmd.scan_run = 1'b1;
                if (sts.scan_end)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                cmd.scan_flush = 1'b1;
                cmd.res_load   = 1'b1;
                cmd.res_status = STATUS_OK;
                cmd.res_leaf   = 1'b1;
                state_next     = ST_DONE;
            end
            ST_DONE:
            begin
                if (!sts.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            mode_reg  <= MODE_INSERT;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
        end
    end

endmodule

FILE: src/array_binary_search_tree.sv
// Insert and search read one node RAM entry per tree level.
// An insert into a full tree and an unused mode load their result without a walk.
// Leaf count: the scan reads one slot of the node RAM per cycle.
// One item is in work at a time; the next item is taken in idle, after the last result is loaded for output.
// After reset a clearing pass empties the node RAM, in_stall high.
// Top level of the array search tree: controller, datapath and checks
`include "assert_macros.svh"

module array_binary_search_tree
    import abst_pkg::*;
#(
    parameter int TREE_LEVELS = TREE_LEVELS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [MODE_W-1:0]       mode,
    input  logic signed [KEY_W-1:0] key,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [STATUS_W-1:0]     status,
    output logic [FIELD_W-1:0]      slot,
    output logic [FIELD_W-1:0]      leaf_count,
    output logic [FIELD_W-1:0]      stored_count
);

    abst_cmd_t cmd;
    abst_sts_t sts;

    abst_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .mode     (mode),
        .sts      (sts),
        .cmd      (cmd)
    );

    abst_datapath
    #(
        .TREE_LEVELS (TREE_LEVELS)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .key          (key),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .status       (status),
        .slot         (slot),
        .leaf_count   (leaf_count),
        .stored_count (stored_count)
    );

    `ASSERT_IMPLIES(a_insert_empty, clk, rst_n, cmd.wr_insert, !sts.node_valid)
    `ASSERT_IMPLIES(a_count_room, clk, rst_n, cmd.cnt_inc, !sts.full)
    `ASSERT_IMPLIES(a_no_accept_clear, clk, rst_n, in_valid && !in_stall, !cmd.clear)
    `ASSERT_NEXT(a_out_load, clk, rst_n, cmd.out_load, out_valid)

endmodule
